// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert that prop holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// assert that cons holds whenever ante holds
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// assert that cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/ult_pkg.sv -----
// ----------------------------------------------------------------------------
// ult_pkg
// Sizes, action codes and status codes of the unordered list table.
// ----------------------------------------------------------------------------
`default_nettype none

package ult_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int INDEX_W     = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   localparam int ACTION_W    = 2;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int NEW_COUNT_W = 8;
   localparam int SLOT_W      = 7;

   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [VALUE_W-1:0] value_type;

   localparam logic [ACTION_W-1:0] ACT_INSERT_BACK  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE       = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_INSERT_SWAP  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_INSERT_SHIFT = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

endpackage

`default_nettype wire

// ----- sv/unordered_list_table_core.sv -----
// ----------------------------------------------------------------------------
// unordered_list_table_core
// Unordered table of signed 32-bit values with append, swap-delete,
// front-swap insert and front-shift insert, one request at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_valid/req_ready carries req_action and req_item_value.
//   Response channel rsp_valid/rsp_ready carries rsp_status, rsp_new_count
//   and rsp_slot; every request yields exactly one response.
//   One request is in flight at a time; req_ready is high only while idle.
//   Steps: an insert into a full table goes straight to the response; an
//   append writes the slot at the count; a front-swap insert copies slot 0
//   to the end, then writes slot 0; a front-shift insert moves each entry up
//   one slot from the back, then writes slot 0; a delete searches from slot
//   0, then moves the last entry into the found slot. The single table read
//   port visits one slot per cycle during the search and the shift. req_ready
//   rises with rsp_valid, so the next request can be taken while it is shown.
//   Reset empties the table at once; no clearing pass is needed since slots
//   beyond the count are never read.
//   A stalled response is held in the output register while the next request
//   is taken and processed; its response then waits, with req_ready low,
//   until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module unordered_list_table_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [ult_pkg::ACTION_W-1:0]     req_action,
   input  wire logic signed [ult_pkg::VALUE_W-1:0] req_item_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [ult_pkg::STATUS_W-1:0]          rsp_status,
   output logic [ult_pkg::NEW_COUNT_W-1:0]       rsp_new_count,
   output logic [ult_pkg::SLOT_W-1:0]            rsp_slot
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_BACK,
      ST_SEARCH,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_SWAP_RD,
      ST_SWAP_WR,
      ST_SHIFT,
      ST_FRONT_WR,
      ST_RESP
   } state_type;

   state_type                        state_ff, state_in;
   logic [ult_pkg::ACTION_W-1:0]     action_ff, action_in;
   ult_pkg::value_type               value_ff, value_in;
   ult_pkg::count_type               count_ff, count_in;
   ult_pkg::count_type               scan_ff, scan_in;
   ult_pkg::index_type               held_ff, held_in;
   logic                             held_valid_ff, held_valid_in;
   logic [ult_pkg::STATUS_W-1:0]     res_status_ff, res_status_in;
   ult_pkg::index_type               res_slot_ff, res_slot_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ult_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [ult_pkg::NEW_COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [ult_pkg::SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;

   ult_pkg::value_type               mem [ult_pkg::TABLE_DEPTH];
   ult_pkg::value_type               rd_data_ff;
   ult_pkg::index_type               rd_addr;
   logic                             wr_en;
   ult_pkg::index_type               wr_addr;
   ult_pkg::value_type               wr_data;

   logic                             full;
   ult_pkg::count_type               last;

   assign full      = (count_ff == ult_pkg::COUNT_W'(ult_pkg::TABLE_DEPTH));
   assign last      = count_ff - ult_pkg::COUNT_W'(1);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_new_count = rsp_count_ff;
   assign rsp_slot      = rsp_slot_ff;

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_slot_in   = rsp_slot_ff;
      rd_addr       = scan_ff[ult_pkg::INDEX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = value_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               action_in     = req_action;
               value_in      = req_item_value;
               scan_in       = '0;
               held_valid_in = 1'b0;
               if (req_action != ult_pkg::ACT_DELETE && full) begin
                  res_status_in = ult_pkg::STAT_FULL;
                  res_slot_in   = '0;
                  state_in      = ST_RESP;
               end else begin
                  case (req_action)
                     ult_pkg::ACT_INSERT_BACK: state_in = ST_INS_BACK;
                     ult_pkg::ACT_DELETE:      state_in = ST_SEARCH;
                     ult_pkg::ACT_INSERT_SWAP: begin
                        state_in = (count_ff == '0) ? ST_FRONT_WR : ST_SWAP_RD;
                     end
                     default: begin
                        scan_in  = count_ff;
                        state_in = ST_SHIFT;
                     end
                  endcase
               end
            end
         end
         ST_INS_BACK: begin
            wr_en         = 1'b1;
            wr_addr       = count_ff[ult_pkg::INDEX_W-1:0];
            count_in      = count_ff + ult_pkg::COUNT_W'(1);
            res_status_in = ult_pkg::STAT_DONE;
            res_slot_in   = count_ff[ult_pkg::INDEX_W-1:0];
            state_in      = ST_RESP;
         end
         ST_SEARCH: begin
            if (held_valid_ff && rd_data_ff == value_ff) begin
               state_in = ST_DEL_RD;
            end else if (scan_ff < count_ff) begin
               held_in       = scan_ff[ult_pkg::INDEX_W-1:0];
               held_valid_in = 1'b1;
               scan_in       = scan_ff + ult_pkg::COUNT_W'(1);
            end else if (held_valid_ff) begin
               held_valid_in = 1'b0;
            end else begin
               res_status_in = ult_pkg::STAT_NOT_FOUND;
               res_slot_in   = '0;
               state_in      = ST_RESP;
            end
         end
         ST_DEL_RD: begin
            rd_addr  = last[ult_pkg::INDEX_W-1:0];
            state_in = ST_DEL_WR;
         end
         ST_DEL_WR: begin
            wr_en         = 1'b1;
            wr_addr       = held_ff;
            wr_data       = rd_data_ff;
            count_in      = last;
            res_status_in = ult_pkg::STAT_DONE;
            res_slot_in   = held_ff;
            state_in      = ST_RESP;
         end
         ST_SWAP_RD: begin
            rd_addr  = '0;
            state_in = ST_SWAP_WR;
         end
         ST_SWAP_WR: begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[ult_pkg::INDEX_W-1:0];
            wr_data  = rd_data_ff;
            state_in = ST_FRONT_WR;
         end
         ST_SHIFT: begin
            if (held_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = held_ff + ult_pkg::INDEX_W'(1);
               wr_data = rd_data_ff;
            end
            if (scan_ff != '0) begin
               rd_addr       = ult_pkg::INDEX_W'(scan_ff - ult_pkg::COUNT_W'(1));
               held_in       = ult_pkg::INDEX_W'(scan_ff - ult_pkg::COUNT_W'(1));
               held_valid_in = 1'b1;
               scan_in       = scan_ff - ult_pkg::COUNT_W'(1);
            end else begin
               held_valid_in = 1'b0;
               if (!held_valid_ff) begin
                  state_in = ST_FRONT_WR;
               end
            end
         end
         ST_FRONT_WR: begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            count_in      = count_ff + ult_pkg::COUNT_W'(1);
            res_status_in = ult_pkg::STAT_DONE;
            res_slot_in   = '0;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_count_in  = ult_pkg::NEW_COUNT_W'(count_ff);
               rsp_slot_in   = ult_pkg::SLOT_W'(res_slot_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      action_ff     <= action_in;
      value_ff      <= value_in;
      scan_ff       <= scan_in;
      held_ff       <= held_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= ult_pkg::COUNT_W'(ult_pkg::TABLE_DEPTH), "count exceeds table depth")
   `ASSERT_NEXT(a_idle_count_hold, clock, reset,
      state_ff == ST_IDLE, count_ff == $past(count_ff), "count changed while idle")
   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset,
      req_valid && req_ready, state_ff != ST_IDLE, "request accepted but sequencer idle")
   `ASSERT_IMPLIES(a_full_count, clock, reset,
      rsp_valid_ff && rsp_status_ff == ult_pkg::STAT_FULL,
      rsp_count_ff == ult_pkg::NEW_COUNT_W'(ult_pkg::TABLE_DEPTH) && rsp_slot_ff == '0,
      "full response with wrong count or slot")
   `ASSERT_IMPLIES(a_insert_kind_full, clock, reset,
      state_ff == ST_SEARCH || state_ff == ST_DEL_RD || state_ff == ST_DEL_WR,
      action_ff == ult_pkg::ACT_DELETE, "delete states entered for an insert")

endmodule

`default_nettype wire

// ----- bench/tb_unordered_list_table_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unordered_list_table_core
// Self-checking bench for the unordered list table. A shadow copy of the
// table predicts status, count and slot for every accepted request; each
// response is compared field by field, in order, against those predictions.
// Traffic walks the table between empty and full under several idle and
// stall mixes, with one long response hold-off.
// ----------------------------------------------------------------------------

module tb_unordered_list_table_core;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int TAIL_CYCLES     = 200;

   typedef struct packed {
      logic [ult_pkg::STATUS_W-1:0]    status;
      logic [ult_pkg::NEW_COUNT_W-1:0] new_count;
      logic [ult_pkg::SLOT_W-1:0]      slot;
   } table_response_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [ult_pkg::ACTION_W-1:0]       req_action = ult_pkg::ACT_INSERT_BACK;
   logic signed [ult_pkg::VALUE_W-1:0] req_item_value = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [ult_pkg::STATUS_W-1:0]       rsp_status;
   logic [ult_pkg::NEW_COUNT_W-1:0]    rsp_new_count;
   logic [ult_pkg::SLOT_W-1:0]         rsp_slot;

   ult_pkg::value_type list_mem [ult_pkg::TABLE_DEPTH];
   int                 list_count = 0;
   table_response_type awaited_responses [$];
   int                 mismatch_count = 0;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   int                 hold_off_serial = 0;
   int                 hold_off_seen = 0;
   int                 hold_off_left = 0;
   int                 quiet_cycles = 0;

   unordered_list_table_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_new_count  (rsp_new_count),
      .rsp_slot       (rsp_slot)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic table_response_type compute_table_response(
      input logic [ult_pkg::ACTION_W-1:0] action, input ult_pkg::value_type value);
      table_response_type resp;
      int idx;
      int found;
      resp = '0;
      if (action == ult_pkg::ACT_DELETE) begin
         found = -1;
         for (idx = 0; idx < list_count; idx++)
            if (found < 0 && list_mem[idx] == value) found = idx;
         if (found < 0) begin
            resp.status    = ult_pkg::STAT_NOT_FOUND;
            resp.new_count = ult_pkg::NEW_COUNT_W'(list_count);
         end else begin
            list_mem[found] = list_mem[list_count-1];
            list_count--;
            resp.status    = ult_pkg::STAT_DONE;
            resp.new_count = ult_pkg::NEW_COUNT_W'(list_count);
            resp.slot      = ult_pkg::SLOT_W'(found);
         end
      end else if (list_count >= ult_pkg::TABLE_DEPTH) begin
         resp.status    = ult_pkg::STAT_FULL;
         resp.new_count = ult_pkg::NEW_COUNT_W'(list_count);
      end else if (action == ult_pkg::ACT_INSERT_BACK) begin
         list_mem[list_count] = value;
         resp.slot = ult_pkg::SLOT_W'(list_count);
         list_count++;
         resp.status    = ult_pkg::STAT_DONE;
         resp.new_count = ult_pkg::NEW_COUNT_W'(list_count);
      end else begin
         if (action == ult_pkg::ACT_INSERT_SWAP) begin
            if (list_count > 0) list_mem[list_count] = list_mem[0];
         end else begin
            for (idx = list_count; idx > 0; idx--) list_mem[idx] = list_mem[idx-1];
         end
         list_mem[0] = value;
         list_count++;
         resp.status    = ult_pkg::STAT_DONE;
         resp.new_count = ult_pkg::NEW_COUNT_W'(list_count);
      end
      return resp;
   endfunction

   function automatic ult_pkg::value_type pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         4, 5: return ult_pkg::value_type'($urandom_range(0, 15));
         default: return ult_pkg::value_type'($urandom());
      endcase
   endfunction

   function automatic ult_pkg::value_type pick_delete_value();
      if (list_count > 0 && $urandom_range(0, 99) < 75)
         return list_mem[$urandom_range(0, list_count - 1)];
      return pick_value();
   endfunction

   function automatic logic [ult_pkg::ACTION_W-1:0] pick_insert_action();
      case ($urandom_range(0, 2))
         0: return ult_pkg::ACT_INSERT_BACK;
         1: return ult_pkg::ACT_INSERT_SWAP;
         default: return ult_pkg::ACT_INSERT_SHIFT;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("%0t mismatch %s: expected %0d got %0d", $time, what, want, got);
      mismatch_count++;
   endtask

   task automatic send_request(input logic [ult_pkg::ACTION_W-1:0] action,
                               input ult_pkg::value_type value);
      table_response_type resp;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_item_value <= value;
      do @(negedge clock); while (req_ready !== 1'b1);
      @(posedge clock);
      resp = compute_table_response(action, value);
      awaited_responses.push_back(resp);
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      do @(negedge clock); while (awaited_responses.size() != 0);
      @(posedge clock);
   endtask

   task automatic set_idling(input int idle, input int stall);
      send_idle_pct = idle;
      recv_stall_pct <= stall;
   endtask

   task automatic test_corner_cases();
      set_idling(0, 0);
      send_request(ult_pkg::ACT_DELETE, 32'h0000_0005);
      send_request(ult_pkg::ACT_INSERT_SWAP, 32'h7FFF_FFFF);
      send_request(ult_pkg::ACT_INSERT_BACK, 32'h8000_0000);
      send_request(ult_pkg::ACT_INSERT_SHIFT, 32'hFFFF_FFFF);
      send_request(ult_pkg::ACT_INSERT_BACK, 32'h0000_0000);
      send_request(ult_pkg::ACT_INSERT_BACK, 32'h8000_0000);
      send_request(ult_pkg::ACT_INSERT_SWAP, 32'h5555_5555);
      send_request(ult_pkg::ACT_INSERT_SHIFT, 32'hAAAA_AAAA);
      send_request(ult_pkg::ACT_DELETE, 32'h8000_0000);
      send_request(ult_pkg::ACT_DELETE, 32'h8000_0000);
      send_request(ult_pkg::ACT_DELETE, 32'h8000_0000);
      send_request(ult_pkg::ACT_DELETE, 32'h7FFF_FFFE);
      send_request(ult_pkg::ACT_DELETE, list_mem[list_count-1]);
      send_request(ult_pkg::ACT_DELETE, list_mem[list_count/2]);
      send_request(ult_pkg::ACT_DELETE, 32'h0000_0000);
      send_request(ult_pkg::ACT_INSERT_SHIFT, 32'h0000_0001);
      send_request(ult_pkg::ACT_DELETE, 32'h0000_0002);
      while (list_count > 0)
         send_request(ult_pkg::ACT_DELETE, list_mem[0]);
      send_request(ult_pkg::ACT_DELETE, 32'hFFFF_FFFF);
      wait_for_responses();
   endtask

   task automatic test_full_table();
      set_idling(0, 0);
      while (list_count < ult_pkg::TABLE_DEPTH)
         send_request(pick_insert_action(), pick_value());
      send_request(ult_pkg::ACT_INSERT_BACK, pick_value());
      send_request(ult_pkg::ACT_INSERT_SWAP, pick_value());
      send_request(ult_pkg::ACT_INSERT_SHIFT, pick_value());
      send_request(ult_pkg::ACT_DELETE, list_mem[ult_pkg::TABLE_DEPTH-1]);
      send_request(ult_pkg::ACT_INSERT_SHIFT, 32'h8000_0000);
      send_request(ult_pkg::ACT_DELETE, list_mem[ult_pkg::TABLE_DEPTH/2]);
      send_request(ult_pkg::ACT_INSERT_SWAP, 32'h7FFF_FFFF);
      send_request(ult_pkg::ACT_DELETE, list_mem[0]);
      send_request(ult_pkg::ACT_INSERT_BACK, 32'hFFFF_FFFF);
      wait_for_responses();
   endtask

   task automatic test_random_traffic(input int n_requests, input int idle, input int stall);
      int k;
      bit filling;
      logic [ult_pkg::ACTION_W-1:0] action;
      ult_pkg::value_type value;
      set_idling(idle, stall);
      filling = (list_count < ult_pkg::TABLE_DEPTH / 2);
      for (k = 0; k < n_requests; k++) begin
         if (list_count >= ult_pkg::TABLE_DEPTH) filling = 1'b0;
         else if (list_count == 0) filling = 1'b1;
         if ($urandom_range(0, 99) < (filling ? 80 : 25)) action = pick_insert_action();
         else action = ult_pkg::ACT_DELETE;
         value = (action == ult_pkg::ACT_DELETE) ? pick_delete_value() : pick_value();
         send_request(action, value);
      end
      wait_for_responses();
   endtask

   task automatic test_backpressure();
      int k;
      set_idling(0, 0);
      hold_off_serial <= hold_off_serial + 1;
      for (k = 0; k < 12; k++) begin
         if ($urandom_range(0, 1) != 0) send_request(pick_insert_action(), pick_value());
         else send_request(ult_pkg::ACT_DELETE, pick_delete_value());
      end
      wait_for_responses();
   endtask

   always @(posedge clock) begin
      if (hold_off_serial != hold_off_seen) begin
         hold_off_seen <= hold_off_serial;
         hold_off_left <= HOLD_OFF_CYCLES;
         rsp_ready     <= 1'b0;
      end else if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_ready     <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_responses
      table_response_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_responses.size() == 0) begin
            report_mismatch("unexpected response, status", -1, rsp_status);
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", want.status, rsp_status);
            if (rsp_new_count !== want.new_count)
               report_mismatch("new_count", want.new_count, rsp_new_count);
            if (rsp_slot !== want.slot)
               report_mismatch("slot", want.slot, rsp_slot);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no request or response moved for %0d cycles", quiet_cycles);
         $display("tb_unordered_list_table_core NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_corner_cases();
      test_full_table();
      test_random_traffic(270, 0, 0);
      test_random_traffic(270, 60, 0);
      test_random_traffic(270, 0, 60);
      test_random_traffic(270, 21, 21);
      test_backpressure();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_responses.size() != 0)
         report_mismatch("responses never received", 0, awaited_responses.size());
      if (mismatch_count == 0) begin
         $display("tb_unordered_list_table_core OK");
      end else begin
         $display("tb_unordered_list_table_core NOT OK");
      end
      $finish;
   end

endmodule
